/* design/ksh_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and controller/datapath command and status structs
package ksh_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CH_W     = ADDR_W + 2;
  localparam int VAL_W    = 32;
  localparam int K_W      = 7;
  localparam int CMP_W    = (CNT_W > K_W) ? CNT_W : K_W;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [K_W-1:0]          rank_t;

  typedef struct packed {
    logic load_item;
    logic ins_start;
    logic set_ovf;
    logic up_read;
    logic up_move;
    logic put_val;
    logic pop_start;
    logic pop_load;
    logic dn_read_l;
    logic dn_cmp_l;
    logic dn_read_r;
    logic dn_cmp_r;
    logic dn_move;
    logic pops_init;
    logic root_read;
    logic res_ok;
    logic res_err;
    logic set_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic count_full;
    logic j_zero;
    logic val_lt_rd;
    logic l_in;
    logic r_in;
    logic m_is_j;
    logic bad_rank;
    logic pops_zero;
    logic out_busy;
  } dp_status_t;

endpackage

/* design/ksh_item_if.sv */
`timescale 1ns / 1ps
// input channel: one set element per beat
interface ksh_item_if;
  logic            valid;
  logic            ready;
  ksh_pkg::value_t value;
  logic            last_item;

  modport source (output valid, value, last_item, input ready);
  modport sink (input valid, value, last_item, output ready);
endinterface

/* design/ksh_result_if.sv */
`timescale 1ns / 1ps
// result channel: selected value and error flag per beat
interface ksh_result_if;
  logic            valid;
  logic            ready;
  ksh_pkg::value_t kth_value;
  logic            rank_error;

  modport source (output valid, kth_value, rank_error, input ready);
  modport sink (input valid, kth_value, rank_error, output ready);
endinterface

/* design/ksh_ram.sv */
`timescale 1ns / 1ps
// generic single-write single-read ram with registered read data
module ksh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/ksh_datapath.sv */
`timescale 1ns / 1ps
// heap datapath: store, hole index, sift registers, rank register, result register
module ksh_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ksh_pkg::dp_cmd_t    cmd,
  output ksh_pkg::dp_status_t status,
  input  ksh_pkg::value_t     item_value,
  input  logic                item_last,
  input  logic                cfg_write,
  input  ksh_pkg::rank_t      cfg_data,
  output logic                result_valid,
  input  logic                result_ready,
  output ksh_pkg::value_t     result_value,
  output logic                result_error
);
  import ksh_pkg::*;

  value_t val;
  value_t best;
  logic   last;
  addr_t  j;
  addr_t  m;
  count_t count;
  logic   ovf;
  rank_t  rank_k;
  rank_t  pops;

  value_t             rd_data;
  logic               rd_en;
  addr_t              rd_addr;
  logic               wr_en;
  value_t             wr_data;
  addr_t              parent;
  logic [CH_W-1:0]    l_idx;
  logic [CH_W-1:0]    r_idx;
  count_t             count_dec;

  assign parent    = addr_t'((j - addr_t'(1)) >> 1);
  assign l_idx     = CH_W'({j, 1'b1});
  assign r_idx     = l_idx + CH_W'(1);
  assign count_dec = count - count_t'(1);

  always_comb begin
    priority if (cmd.up_read) begin
      rd_addr = parent;
    end else if (cmd.pop_start) begin
      rd_addr = count_dec[ADDR_W-1:0];
    end else if (cmd.dn_read_l) begin
      rd_addr = l_idx[ADDR_W-1:0];
    end else if (cmd.dn_read_r) begin
      rd_addr = r_idx[ADDR_W-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  assign rd_en = cmd.up_read | cmd.pop_start | cmd.dn_read_l | cmd.dn_read_r | cmd.root_read;
  assign wr_en = cmd.up_move | cmd.put_val | cmd.dn_move;

  always_comb begin
    priority if (cmd.up_move) begin
      wr_data = rd_data;
    end else if (cmd.put_val) begin
      wr_data = val;
    end else begin
      wr_data = best;
    end
  end

  ksh_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (j),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sift registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      val  <= item_value;
      last <= item_last;
    end
    if (cmd.ins_start) begin
      j <= count[ADDR_W-1:0];
    end
    if (cmd.up_move) begin
      j <= parent;
    end
    if (cmd.pop_load) begin
      val <= rd_data;
      j   <= '0;
    end
    if (cmd.dn_cmp_l) begin
      if (rd_data < val) begin
        best <= rd_data;
        m    <= l_idx[ADDR_W-1:0];
      end else begin
        best <= val;
        m    <= j;
      end
    end
    if (cmd.dn_cmp_r && (rd_data < best)) begin
      best <= rd_data;
      m    <= r_idx[ADDR_W-1:0];
    end
    if (cmd.dn_move) begin
      j <= m;
    end
    if (cmd.pops_init) begin
      pops <= rank_k - rank_t'(1);
    end
    if (cmd.pop_start) begin
      pops <= pops - rank_t'(1);
    end
    if (cmd.res_ok) begin
      result_value <= rd_data;
      result_error <= 1'b0;
    end
    if (cmd.res_err) begin
      result_value <= '0;
      result_error <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      rank_k       <= rank_t'(1);
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        rank_k <= cfg_data;
      end
      if (cmd.ins_start) begin
        count <= count + count_t'(1);
      end
      if (cmd.pop_start) begin
        count <= count_dec;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.set_clear) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.res_ok || cmd.res_err) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign status.last       = last;
  assign status.count_full = (count == count_t'(CAPACITY));
  assign status.j_zero     = (j == '0);
  assign status.val_lt_rd  = (val < rd_data);
  assign status.l_in       = (l_idx < CH_W'(count));
  assign status.r_in       = (r_idx < CH_W'(count));
  assign status.m_is_j     = (m == j);
  assign status.bad_rank   = ovf || (rank_k == '0) || (CMP_W'(rank_k) > CMP_W'(count));
  assign status.pops_zero  = (pops == '0);
  assign status.out_busy   = result_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(CAPACITY))
    else $error("heap count beyond capacity");

  // a pop always leaves at least one entry for the root read
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_start |-> count >= count_t'(2))
    else $error("pop on a heap with fewer than two entries");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_ok || cmd.res_err) |-> !result_valid)
    else $error("result register overwritten before taken");

endmodule

/* design/ksh_ctrl.sv */
`timescale 1ns / 1ps
// controller: sequences insert sift-up, pops with sift-down and root read
module ksh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  ksh_pkg::dp_status_t status,
  output ksh_pkg::dp_cmd_t    cmd
);
  import ksh_pkg::*;

  typedef enum logic [11:0] {
    IDLE     = 12'b000000000001,
    UP_START = 12'b000000000010,
    UP_RD    = 12'b000000000100,
    UP_CMP   = 12'b000000001000,
    CHECK    = 12'b000000010000,
    POP_CHK  = 12'b000000100000,
    POP_LD   = 12'b000001000000,
    DN_L     = 12'b000010000000,
    DN_LC    = 12'b000100000000,
    DN_RC    = 12'b001000000000,
    DN_MV    = 12'b010000000000,
    ROOT     = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = UP_START;
        end
      end
      UP_START: begin
        if (status.count_full) begin
          cmd.set_ovf = 1'b1;
          state_next  = status.last ? CHECK : IDLE;
        end else begin
          cmd.ins_start = 1'b1;
          state_next    = UP_RD;
        end
      end
      UP_RD: begin
        if (status.j_zero) begin
          cmd.put_val = 1'b1;
          state_next  = status.last ? CHECK : IDLE;
        end else begin
          cmd.up_read = 1'b1;
          state_next  = UP_CMP;
        end
      end
      UP_CMP: begin
        if (status.val_lt_rd) begin
          cmd.up_move = 1'b1;
          state_next  = UP_RD;
        end else begin
          cmd.put_val = 1'b1;
          state_next  = status.last ? CHECK : IDLE;
        end
      end
      CHECK: begin
        // wait for the result register to drain
        if (!status.out_busy) begin
          if (status.bad_rank) begin
            cmd.res_err   = 1'b1;
            cmd.set_clear = 1'b1;
            state_next    = IDLE;
          end else begin
            cmd.pops_init = 1'b1;
            state_next    = POP_CHK;
          end
        end
      end
      POP_CHK: begin
        if (status.pops_zero) begin
          cmd.root_read = 1'b1;
          state_next    = ROOT;
        end else begin
          cmd.pop_start = 1'b1;
          state_next    = POP_LD;
        end
      end
      POP_LD: begin
        cmd.pop_load = 1'b1;
        state_next   = DN_L;
      end
      DN_L: begin
        if (status.l_in) begin
          cmd.dn_read_l = 1'b1;
          state_next    = DN_LC;
        end else begin
          cmd.put_val = 1'b1;
          state_next  = POP_CHK;
        end
      end
      DN_LC: begin
        cmd.dn_cmp_l = 1'b1;
        if (status.r_in) begin
          cmd.dn_read_r = 1'b1;
          state_next    = DN_RC;
        end else begin
          state_next = DN_MV;
        end
      end
      DN_RC: begin
        cmd.dn_cmp_r = 1'b1;
        state_next   = DN_MV;
      end
      DN_MV: begin
        if (status.m_is_j) begin
          cmd.put_val = 1'b1;
          state_next  = POP_CHK;
        end else begin
          cmd.dn_move = 1'b1;
          state_next  = DN_L;
        end
      end
      ROOT: begin
        cmd.res_ok    = 1'b1;
        cmd.set_clear = 1'b1;
        state_next    = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/kth_smallest_heap_select.sv */
`timescale 1ns / 1ps
// top level: k-th smallest selector over a min-heap store
//
//   channel  | dir | beat contents                 | handshake
//   ---------+-----+-------------------------------+------------------
//   item     | in  | value, last_item              | valid / ready
//   result   | out | kth_value, rank_error         | valid / ready
//   cfg      | in  | cfg_data (rank_k)             | cfg_write
//
// an element: accepted in IDLE, then inserted with a sift-up that reads each parent and moves
//   it down while the new value is smaller; the store has one read port
// a closing element adds a rank check, then per removal a load of the last entry and a sift-down
//   that reads and compares the left and right child of each hole, then the root read
// synchronous reset: empty heap, rank_k = 1, no result pending; no clearing pass
// a result beat holds until taken; the next set loads, only its closing element waits
module kth_smallest_heap_select (
  input  logic                 clk,
  input  logic                 rst,
  ksh_item_if.sink             item,
  ksh_result_if.source         result,
  input  logic                 cfg_write,
  input  ksh_pkg::rank_t       cfg_data
);
  import ksh_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ksh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  ksh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item_value   (item.value),
    .item_last    (item.last_item),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_value (result.kth_value),
    .result_error (result.rank_error)
  );

endmodule
